// ===== rtl/nfcs_pkg.sv =====
// ----------------------------------------------------------------------------
// nfcs_pkg
// Shared types, bus command codes and result builders for the NOR flash
// command sequencer.
// ----------------------------------------------------------------------------
package nfcs_pkg;

  localparam int unsigned ADDR_BITS   = 21;
  localparam int unsigned DATA_BITS   = 32;
  localparam int unsigned MAX_RESULTS = 7;
  localparam int unsigned CNT_BITS    = 3;   // holds 0..MAX_RESULTS
  localparam int unsigned POS_BITS    = 3;   // indexes 0..MAX_RESULTS-1

  // Command words, replicated for both interleaved x16 chips
  localparam logic [DATA_BITS-1:0] CMD_RESET   = 32'h00F0_00F0;
  localparam logic [DATA_BITS-1:0] CMD_UNLK1   = 32'h00AA_00AA;
  localparam logic [DATA_BITS-1:0] CMD_UNLK2   = 32'h0055_0055;
  localparam logic [DATA_BITS-1:0] CMD_AUTOSEL = 32'h0090_0090;
  localparam logic [DATA_BITS-1:0] CMD_ERASE   = 32'h0080_0080;
  localparam logic [DATA_BITS-1:0] CMD_PROG    = 32'h00A0_00A0;
  localparam logic [DATA_BITS-1:0] CMD_SECTOR  = 32'h0030_0030;
  localparam logic [DATA_BITS-1:0] DQ5_BOTH    = 32'h0020_0020;
  localparam logic [DATA_BITS-1:0] DQ7_BOTH    = 32'h0080_0080;

  localparam logic [ADDR_BITS-1:0] OFF_A = ADDR_BITS'(12'h555);
  localparam logic [ADDR_BITS-1:0] OFF_B = ADDR_BITS'(12'h2AA);

  localparam logic [DATA_BITS-1:0] READY_MASK_RST = 32'h0080_0080;

  typedef enum logic [1:0] {
    OP_PROGRAM   = 2'd0,
    OP_ERASE     = 2'd1,
    OP_READ_ID   = 2'd2,
    OP_READ_DATA = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_PROTECTED   = 3'd1,
    ST_NEEDS_ERASE = 3'd2,
    ST_DEVICE_ERR  = 3'd3,
    ST_VERIFY_ERR  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_WRITE_PROTECT = 2'd0,
    CFG_READY_MASK    = 2'd1,
    CFG_FLASH_BASE    = 2'd2
  } cfg_idx_e;

  typedef enum logic [9:0] {
    PH_IDLE      = 10'b00_0000_0001,
    PH_P_CUR     = 10'b00_0000_0010,
    PH_P_POLL    = 10'b00_0000_0100,
    PH_P_DQ7     = 10'b00_0000_1000,
    PH_P_VER     = 10'b00_0001_0000,
    PH_P_VER_ERR = 10'b00_0010_0000,
    PH_E_POLL    = 10'b00_0100_0000,
    PH_E_DQ7     = 10'b00_1000_0000,
    PH_ID_MAN    = 10'b01_0000_0000,
    PH_ID_DEV    = 10'b10_0000_0000
  } phase_e;

  typedef struct packed {
    op_e                  operation;
    logic [ADDR_BITS-1:0] word_address;
    logic [DATA_BITS-1:0] write_data;
    logic [DATA_BITS-1:0] read_data;
  } nfcs_in_t;

  typedef struct packed {
    kind_e                kind;
    logic [ADDR_BITS-1:0] bus_address;
    logic [DATA_BITS-1:0] bus_data;
    status_e              status;
    logic [DATA_BITS-1:0] manufacturer_code;
    logic [DATA_BITS-1:0] device_code;
    logic                 last;
  } nfcs_out_t;

  typedef nfcs_out_t [MAX_RESULTS-1:0] nfcs_list_t;

  typedef struct packed {
    logic                 write_protect;
    logic [DATA_BITS-1:0] ready_mask;
    logic [ADDR_BITS-1:0] flash_base;
  } nfcs_cfg_t;

  // Sequencer to top level: what the step just decoded
  typedef struct packed {
    logic                busy;    // a command was in progress before this step
    logic [CNT_BITS-1:0] count;   // number of results the step produces
  } nfcs_info_t;

  function automatic nfcs_out_t res_write(input logic [ADDR_BITS-1:0] addr,
                                          input logic [DATA_BITS-1:0] data);
    nfcs_out_t r;
    r             = '0;
    r.kind        = KIND_WRITE;
    r.bus_address = addr;
    r.bus_data    = data;
    return r;
  endfunction

  function automatic nfcs_out_t res_read(input logic [ADDR_BITS-1:0] addr);
    nfcs_out_t r;
    r             = '0;
    r.kind        = KIND_READ;
    r.bus_address = addr;
    return r;
  endfunction

  function automatic nfcs_out_t res_done(input status_e st,
                                         input logic [DATA_BITS-1:0] man,
                                         input logic [DATA_BITS-1:0] dev);
    nfcs_out_t r;
    r                   = '0;
    r.kind              = KIND_DONE;
    r.status            = st;
    r.manufacturer_code = man;
    r.device_code       = dev;
    return r;
  endfunction

  // Data-polling failure: DQ5 set in a half whose DQ7 still disagrees
  function automatic logic dq5_fail(input logic [DATA_BITS-1:0] s,
                                    input logic [DATA_BITS-1:0] d,
                                    input logic [DATA_BITS-1:0] expect_dq7);
    return (s[5]  && (d[7]  != expect_dq7[7])) ||
           (s[21] && (d[23] != expect_dq7[23]));
  endfunction

endpackage

// ===== rtl/nor_flash_command_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// nor_flash_command_sequencer_top
// Host-side command sequencer for two interleaved x16 AMD-style NOR flash
// chips on a 32-bit bus: program word, erase sector, read ID.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid_i/in_stall_o    nfcs_in_t  (command or read data)
//   out      source     out_valid_o/out_stall_i  nfcs_out_t (write, read, done)
//   cfg      sink       cfg_we_i, cfg_index_i    cfg_wdata_i
//
// An accepted item waits in the input register until the buffer can load, is
// decoded in one pass and its 0..7 results load the output buffer.
// The buffer drives one result transfer per cycle while out is not stalled;
// the single result port sets the rate.
// The next item is taken while the last result of the previous one is out.
// Reset clears the phase and the command target and sets the config registers to their defaults.
// A stall on out backs up through the buffer into in_stall_o.
// ----------------------------------------------------------------------------
module nor_flash_command_sequencer_top import nfcs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command / read-data channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  nfcs_in_t             in_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output nfcs_out_t            out_o,
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [DATA_BITS-1:0] cfg_wdata_i
);

  // Configuration registers
  nfcs_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.write_protect <= 1'b0;
      cfg_q.ready_mask    <= READY_MASK_RST;
      cfg_q.flash_base    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WRITE_PROTECT: cfg_q.write_protect <= cfg_wdata_i[0];
        CFG_READY_MASK:    cfg_q.ready_mask    <= cfg_wdata_i;
        CFG_FLASH_BASE:    cfg_q.flash_base    <= cfg_wdata_i[ADDR_BITS-1:0];
        default: begin
          // unmapped index: write dropped
        end
      endcase
    end
  end

  // Input register: holds one item until the buffer can take its results
  logic       in_valid_q;
  nfcs_in_t   in_q;
  logic       in_take;
  logic       step;
  logic       load_ready;
  nfcs_list_t list;
  nfcs_info_t info;

  assign step       = in_valid_q && load_ready;
  assign in_stall_o = in_valid_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_i;
    end
  end

  // Phase state and single-pass decode
  nfcs_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .list_o (list),
    .info_o (info)
  );

  // Result buffer, one transfer per cycle while out is not stalled
  nfcs_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (step),
    .list_i       (list),
    .count_i      (info.count),
    .load_ready_o (load_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_o        (out_o)
  );

  // A command arriving mid-sequence is dropped without results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && (in_q.operation != OP_READ_DATA) && info.busy |-> info.count == '0)
    else $error("command accepted while busy produced results");

  // A completion always closes the result list of its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.kind == KIND_DONE) |-> out_o.last)
    else $error("completion not marked as final result");

  // Decoded results show up at the output on the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && (info.count != '0) |=> out_valid_o)
    else $error("decoded results not presented");

  // Input register never stalls while the result buffer is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result buffer");

endmodule

// ===== rtl/nfcs_seq.sv =====
// ----------------------------------------------------------------------------
// nfcs_seq
// Command state and single-pass decode: one item in, its full result list
// and the next phase out.
// ----------------------------------------------------------------------------
module nfcs_seq import nfcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  nfcs_in_t   item_i,
  input  nfcs_cfg_t  cfg_i,
  output nfcs_list_t list_o,
  output nfcs_info_t info_o
);

  phase_e               phase_q, phase_d;
  logic [ADDR_BITS-1:0] taddr_q, taddr_d;
  logic [DATA_BITS-1:0] tdata_q, tdata_d;
  logic [DATA_BITS-1:0] sample_q, sample_d;
  logic [DATA_BITS-1:0] man_q, man_d;

  logic [ADDR_BITS-1:0] addr_base, addr_a, addr_b, addr_1;
  logic [DATA_BITS-1:0] rd;
  logic                 prog_ready, erase_ready;
  logic [CNT_BITS-1:0]  count;

  assign addr_base   = cfg_i.flash_base;
  assign addr_a      = addr_base + OFF_A;
  assign addr_b      = addr_base + OFF_B;
  assign addr_1      = addr_base + ADDR_BITS'(1);
  assign rd          = item_i.read_data;
  assign prog_ready  = (rd & cfg_i.ready_mask) == (tdata_q & cfg_i.ready_mask);
  assign erase_ready = (rd & cfg_i.ready_mask) == cfg_i.ready_mask;

  always_comb begin
    list_o   = '0;
    count    = '0;
    phase_d  = phase_q;
    taddr_d  = taddr_q;
    tdata_d  = tdata_q;
    sample_d = sample_q;
    man_d    = man_q;

    if (item_i.operation == OP_READ_DATA) begin
      unique case (phase_q) inside
        PH_IDLE: begin
          // no read outstanding: dropped
        end
        PH_P_CUR: begin
          if (rd == tdata_q) begin
            list_o[0] = res_done(ST_OK, '0, '0);
            count     = CNT_BITS'(1);
            phase_d   = PH_IDLE;
          end else if ((tdata_q & ~rd) != '0) begin
            list_o[0] = res_done(ST_NEEDS_ERASE, '0, '0);
            count     = CNT_BITS'(1);
            phase_d   = PH_IDLE;
          end else begin
            list_o[0] = res_write(addr_base, CMD_RESET);
            list_o[1] = res_write(addr_a, CMD_UNLK1);
            list_o[2] = res_write(addr_b, CMD_UNLK2);
            list_o[3] = res_write(addr_a, CMD_PROG);
            list_o[4] = res_write(taddr_q, tdata_q);
            list_o[5] = res_read(taddr_q);
            count     = CNT_BITS'(6);
            phase_d   = PH_P_POLL;
          end
        end
        PH_P_POLL, PH_E_POLL: begin
          if ((phase_q == PH_P_POLL) ? prog_ready : erase_ready) begin
            list_o[0] = res_write(addr_base, CMD_RESET);
            if (phase_q == PH_P_POLL) begin
              list_o[1] = res_read(taddr_q);
              phase_d   = PH_P_VER;
            end else begin
              list_o[1] = res_done(ST_OK, '0, '0);
              phase_d   = PH_IDLE;
            end
            count = CNT_BITS'(2);
          end else begin
            list_o[0] = res_read(taddr_q);
            count     = CNT_BITS'(1);
            if ((rd & DQ5_BOTH) != '0) begin
              sample_d = rd;
              phase_d  = (phase_q == PH_P_POLL) ? PH_P_DQ7 : PH_E_DQ7;
            end
          end
        end
        PH_P_DQ7: begin
          if (dq5_fail(sample_q, rd, tdata_q)) begin
            list_o[0] = res_write(addr_base, CMD_RESET);
            list_o[1] = res_read(taddr_q);
            count     = CNT_BITS'(2);
            phase_d   = PH_P_VER_ERR;
          end else begin
            list_o[0] = res_read(taddr_q);
            count     = CNT_BITS'(1);
            phase_d   = PH_P_POLL;
          end
        end
        PH_E_DQ7: begin
          if (dq5_fail(sample_q, rd, DQ7_BOTH)) begin
            list_o[0] = res_write(addr_base, CMD_RESET);
            list_o[1] = res_done(ST_DEVICE_ERR, '0, '0);
            count     = CNT_BITS'(2);
            phase_d   = PH_IDLE;
          end else begin
            list_o[0] = res_read(taddr_q);
            count     = CNT_BITS'(1);
            phase_d   = PH_E_POLL;
          end
        end
        PH_P_VER, PH_P_VER_ERR: begin
          if (rd == tdata_q) begin
            list_o[0] = res_done(ST_OK, '0, '0);
          end else if (phase_q == PH_P_VER_ERR) begin
            list_o[0] = res_done(ST_DEVICE_ERR, '0, '0);
          end else begin
            list_o[0] = res_done(ST_VERIFY_ERR, '0, '0);
          end
          count   = CNT_BITS'(1);
          phase_d = PH_IDLE;
        end
        PH_ID_MAN: begin
          man_d     = rd;
          list_o[0] = res_read(addr_1);
          count     = CNT_BITS'(1);
          phase_d   = PH_ID_DEV;
        end
        PH_ID_DEV: begin
          list_o[0] = res_write(addr_base, CMD_RESET);
          list_o[1] = res_done(ST_OK, man_q, rd);
          count     = CNT_BITS'(2);
          phase_d   = PH_IDLE;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end else if (phase_q == PH_IDLE) begin
      unique case (item_i.operation)
        OP_PROGRAM: begin
          if (cfg_i.write_protect) begin
            list_o[0] = res_done(ST_PROTECTED, '0, '0);
            count     = CNT_BITS'(1);
          end else begin
            taddr_d   = item_i.word_address;
            tdata_d   = item_i.write_data;
            list_o[0] = res_read(item_i.word_address);
            count     = CNT_BITS'(1);
            phase_d   = PH_P_CUR;
          end
        end
        OP_ERASE: begin
          if (cfg_i.write_protect) begin
            list_o[0] = res_done(ST_PROTECTED, '0, '0);
            count     = CNT_BITS'(1);
          end else begin
            taddr_d   = item_i.word_address;
            list_o[0] = res_write(addr_a, CMD_UNLK1);
            list_o[1] = res_write(addr_b, CMD_UNLK2);
            list_o[2] = res_write(addr_a, CMD_ERASE);
            list_o[3] = res_write(addr_a, CMD_UNLK1);
            list_o[4] = res_write(addr_b, CMD_UNLK2);
            list_o[5] = res_write(item_i.word_address, CMD_SECTOR);
            list_o[6] = res_read(item_i.word_address);
            count     = CNT_BITS'(7);
            phase_d   = PH_E_POLL;
          end
        end
        default: begin  // read identifier
          list_o[0] = res_write(addr_base, CMD_RESET);
          list_o[1] = res_write(addr_a, CMD_UNLK1);
          list_o[2] = res_write(addr_b, CMD_UNLK2);
          list_o[3] = res_write(addr_a, CMD_AUTOSEL);
          list_o[4] = res_read(addr_base);
          count     = CNT_BITS'(5);
          phase_d   = PH_ID_MAN;
        end
      endcase
    end
    // a command while busy falls through with no results
  end

  assign info_o.busy  = (phase_q != PH_IDLE);
  assign info_o.count = count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      taddr_q  <= '0;
      tdata_q  <= '0;
      sample_q <= '0;
      man_q    <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      taddr_q  <= taddr_d;
      tdata_q  <= tdata_d;
      sample_q <= sample_d;
      man_q    <= man_d;
    end
  end

endmodule

// ===== rtl/nfcs_emit.sv =====
// ----------------------------------------------------------------------------
// nfcs_emit
// Result buffer: holds the decoded list of one item and hands it out one
// transfer per cycle while out is not stalled, marking the final entry.
// ----------------------------------------------------------------------------
module nfcs_emit import nfcs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  nfcs_list_t          list_i,
  input  logic [CNT_BITS-1:0] count_i,
  output logic                load_ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output nfcs_out_t           out_o
);

  nfcs_list_t          buf_q;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic                take;

  assign out_valid_o  = (cnt_q != '0);
  assign take         = out_valid_o && !out_stall_i;
  assign load_ready_o = (cnt_q == '0) || ((cnt_q == CNT_BITS'(1)) && take);

  always_comb begin
    out_o      = buf_q[pos_q];
    out_o.last = (cnt_q == CNT_BITS'(1));
  end

  always_comb begin
    cnt_d = cnt_q;
    pos_d = pos_q;
    if (load_i) begin
      cnt_d = count_i;
      pos_d = '0;
    end else if (take) begin
      cnt_d = cnt_q - CNT_BITS'(1);
      pos_d = pos_q + POS_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      pos_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= list_i;
    end
  end

endmodule
